// ===== rtl/gkp_pkg.sv =====
// Shared constants, types and register codes for the gap-keeping speed controller.
`default_nettype none

package gkp_pkg;

	// default widths of the speed and gap fields
	localparam int DATA_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF  = 8;

	// gains are unsigned Q4.12
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 12;

	// threshold and integral limit registers
	localparam int LIMIT_W = 23;

	// integral accumulator
	localparam int ACC_W = 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// reset values: gains as raw Q4.12, limits in whole units
	localparam logic [GAIN_W-1:0] KP_RESET = 16'd8192;
	localparam logic [GAIN_W-1:0] KI_RESET = 16'd819;
	localparam logic [GAIN_W-1:0] KD_RESET = 16'd0;
	localparam int SLOW_SPEED_UNITS = 80;
	localparam int INT_LIMIT_UNITS  = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP_NORMAL   = 3'd0,
		CFG_KI_NORMAL   = 3'd1,
		CFG_KD_GAIN     = 3'd2,
		CFG_KP_SLOW     = 3'd3,
		CFG_KI_SLOW     = 3'd4,
		CFG_SLOW_THRESH = 3'd5,
		CFG_INT_LIMIT   = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  kp_normal;
		logic [GAIN_W-1:0]  ki_normal;
		logic [GAIN_W-1:0]  kd_gain;
		logic [GAIN_W-1:0]  kp_slow;
		logic [GAIN_W-1:0]  ki_slow;
		logic [LIMIT_W-1:0] slow_speed_threshold;
		logic [LIMIT_W-1:0] integral_limit;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/gkp_if.sv =====
// Valid/ready channels for measurement items and command items.
`default_nettype none

interface gkp_meas_if import gkp_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] gap_measured;
	logic signed [DATA_WIDTH-1:0] gap_target;
	logic signed [DATA_WIDTH-1:0] leader_speed_a;
	logic signed [DATA_WIDTH-1:0] leader_speed_b;
	logic signed [DATA_WIDTH-1:0] own_speed;

	modport source (
		output valid, gap_measured, gap_target, leader_speed_a, leader_speed_b, own_speed,
		input  ready
	);
	modport sink (
		input  valid, gap_measured, gap_target, leader_speed_a, leader_speed_b, own_speed,
		output ready
	);
endinterface

interface gkp_cmd_if import gkp_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] speed_command;
	logic                         in_deadband;
	logic                         slow_gains_active;

	modport source (
		output valid, speed_command, in_deadband, slow_gains_active,
		input  ready
	);
	modport sink (
		input  valid, speed_command, in_deadband, slow_gains_active,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/gkp_cfg_regs.sv =====
// Configuration register file: gains, low-speed threshold and integral limit.
`default_nettype none

module gkp_cfg_regs import gkp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	localparam logic [LIMIT_W-1:0] THRESH_RESET = LIMIT_W'(SLOW_SPEED_UNITS << FRAC_BITS);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(INT_LIMIT_UNITS << FRAC_BITS);

	cfg_t cfg_q;

	// register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_normal            <= KP_RESET;
			cfg_q.ki_normal            <= KI_RESET;
			cfg_q.kd_gain              <= KD_RESET;
			cfg_q.kp_slow              <= KP_RESET;
			cfg_q.ki_slow              <= KI_RESET;
			cfg_q.slow_speed_threshold <= THRESH_RESET;
			cfg_q.integral_limit       <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_KP_NORMAL:   cfg_q.kp_normal            <= cfg_wdata[GAIN_W-1:0];
				CFG_KI_NORMAL:   cfg_q.ki_normal            <= cfg_wdata[GAIN_W-1:0];
				CFG_KD_GAIN:     cfg_q.kd_gain              <= cfg_wdata[GAIN_W-1:0];
				CFG_KP_SLOW:     cfg_q.kp_slow              <= cfg_wdata[GAIN_W-1:0];
				CFG_KI_SLOW:     cfg_q.ki_slow              <= cfg_wdata[GAIN_W-1:0];
				CFG_SLOW_THRESH: cfg_q.slow_speed_threshold <= cfg_wdata[LIMIT_W-1:0];
				CFG_INT_LIMIT:   cfg_q.integral_limit       <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/gkp_datapath.sv =====
// Single-pass PID arithmetic: error, deadband, integral update, three terms, saturation.
`default_nettype none

module gkp_datapath import gkp_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire cfg_t                         cfg,
	input  wire logic signed [DATA_WIDTH-1:0] gap_measured,
	input  wire logic signed [DATA_WIDTH-1:0] gap_target,
	input  wire logic signed [DATA_WIDTH-1:0] leader_speed_a,
	input  wire logic signed [DATA_WIDTH-1:0] leader_speed_b,
	input  wire logic signed [DATA_WIDTH-1:0] own_speed,
	input  wire logic signed [DATA_WIDTH-1:0] prev_err,
	input  wire logic signed [ACC_W-1:0]      err_sum,
	input  wire logic                         slow_latch,
	output logic signed [DATA_WIDTH-1:0]      prev_err_nxt,
	output logic signed [ACC_W-1:0]           err_sum_nxt,
	output logic                              slow_latch_nxt,
	output logic signed [DATA_WIDTH-1:0]      speed_command,
	output logic                              in_deadband
);

	localparam int W      = DATA_WIDTH;
	localparam int CMP_W  = ((W > LIMIT_W + 1) ? W : LIMIT_W + 1) + 1;
	localparam int SUM_W  = ((W > ACC_W) ? W : ACC_W) + 1;
	localparam int PW     = W + GAIN_W + 1;
	localparam int IPW    = ACC_W + GAIN_W + 1;
	localparam int CMD_W  = ((PW > IPW) ? PW : IPW) + 2;
	localparam logic signed [W+1:0] ONE = (W+2)'(1) << FRAC_BITS;
	localparam logic signed [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] AMAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] AMIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic signed [W-1:0]       vf;
	logic signed [CMP_W-1:0]   vf_c, thr_c;
	logic signed [16:0]        kp_s, ki_s, kd_s;
	logic signed [W:0]         err_w, diff_w;
	logic signed [W-1:0]       err, diff;
	logic signed [W+1:0]       err_e;
	logic                      dead;
	logic signed [ACC_W:0]     sum_c, lim_c;
	logic signed [SUM_W-1:0]   sum_w;
	logic signed [ACC_W-1:0]   sum_sat, sum_upd;
	logic signed [PW-1:0]      p_p, p_d, t_p, t_d;
	logic signed [IPW-1:0]     p_i, t_i;
	logic signed [CMD_W-1:0]   cmd_w;
	logic                      cmd_ovf;
	logic signed [W-1:0]       cmd_sat;

	// followed speed and sticky low-speed latch
	assign vf    = (leader_speed_a == leader_speed_b) ? leader_speed_a : own_speed;
	assign vf_c  = CMP_W'(vf);
	assign thr_c = CMP_W'({1'b0, cfg.slow_speed_threshold});
	assign slow_latch_nxt = slow_latch | (vf_c < thr_c);

	// gains after the latch update
	assign kp_s = {1'b0, slow_latch_nxt ? cfg.kp_slow : cfg.kp_normal};
	assign ki_s = {1'b0, slow_latch_nxt ? cfg.ki_slow : cfg.ki_normal};
	assign kd_s = {1'b0, cfg.kd_gain};

	// saturated gap error and deadband
	assign err_w = (W+1)'(gap_measured) - (W+1)'(gap_target);
	assign err   = (err_w[W] != err_w[W-1]) ? (err_w[W] ? DMIN : DMAX) : err_w[W-1:0];
	assign err_e = (W+2)'(err);
	assign dead  = (err_e < ONE) && (err_e > -ONE);

	// saturated derivative difference
	assign diff_w = (W+1)'(err) - (W+1)'(prev_err);
	assign diff   = (diff_w[W] != diff_w[W-1]) ? (diff_w[W] ? DMIN : DMAX) : diff_w[W-1:0];

	// gated integral with 32-bit saturation
	assign sum_c = (ACC_W+1)'(err_sum);
	assign lim_c = (ACC_W+1)'({1'b0, cfg.integral_limit});
	assign sum_w = SUM_W'(err_sum) + SUM_W'(err);
	always_comb begin
		if ((&sum_w[SUM_W-1:ACC_W-1]) || !(|sum_w[SUM_W-1:ACC_W-1])) begin
			sum_sat = sum_w[ACC_W-1:0];
		end else begin
			sum_sat = sum_w[SUM_W-1] ? AMIN : AMAX;
		end
	end
	assign sum_upd = (sum_c < lim_c) ? sum_sat : err_sum;

	// P, I and D terms, each floored after the gain shift
	assign p_p = PW'(kp_s) * PW'(err);
	assign p_i = IPW'(ki_s) * IPW'(sum_upd);
	assign p_d = PW'(kd_s) * PW'(diff);
	assign t_p = p_p >>> GAIN_FRAC;
	assign t_i = p_i >>> GAIN_FRAC;
	assign t_d = p_d >>> GAIN_FRAC;

	// command sum and saturation
	assign cmd_w   = CMD_W'(vf) + CMD_W'(t_p) + CMD_W'(t_i) + CMD_W'(t_d);
	assign cmd_ovf = !((&cmd_w[CMD_W-1:W-1]) || !(|cmd_w[CMD_W-1:W-1]));
	assign cmd_sat = cmd_ovf ? (cmd_w[CMD_W-1] ? DMIN : DMAX) : cmd_w[W-1:0];

	// deadband passes speed through and clears the integral
	assign speed_command = dead ? vf : cmd_sat;
	assign in_deadband   = dead;
	assign err_sum_nxt   = dead ? '0 : sum_upd;
	assign prev_err_nxt  = dead ? prev_err : err;

endmodule

`default_nettype wire

// ===== rtl/gap_keeping_pid_speed_top.sv =====
// Top level of the gap-keeping PID speed controller.
// Takes one measurement item per clock while cmd is not stalled and returns one speed
// command per item. Each item sits in an input register, passes the error, deadband,
// integral update and the three gain multiplies in one combinational pass, and lands in
// a result register. Throughput is one item per cycle while cmd is not stalled, set by
// that single pass, since the integral, previous error and low-speed latch of one item
// feed the next. While a finished command waits on the output, the input register can
// take one more item and then stalls the input. The user must write gains and limits
// through the cfg port only while no item is in flight; the block does not enforce it.
// The slow-gain latch, once set by a followed speed under the threshold, holds until reset.
`default_nettype none

module gap_keeping_pid_speed_top import gkp_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	gkp_meas_if.sink                   meas,
	gkp_cmd_if.source                  cmd
);

	localparam int W = DATA_WIDTH;

	cfg_t cfg;

	logic                valid_s1;
	logic signed [W-1:0] gap_measured_s1, gap_target_s1;
	logic signed [W-1:0] leader_speed_a_s1, leader_speed_b_s1, own_speed_s1;

	logic                valid_s2;
	logic signed [W-1:0] speed_command_s2;
	logic                in_deadband_s2, slow_gains_active_s2;

	logic signed [W-1:0]     prev_err_q;
	logic signed [ACC_W-1:0] err_sum_q;
	logic                    slow_latch_q;

	logic signed [W-1:0]     prev_err_nxt;
	logic signed [ACC_W-1:0] err_sum_nxt;
	logic                    slow_latch_nxt;
	logic signed [W-1:0]     speed_command_nxt;
	logic                    in_deadband_nxt;

	logic accept, advance;

	gkp_cfg_regs #(
		.FRAC_BITS (FRAC_BITS)
	) u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// handshake: stage 1 moves on when the result register is free or being drained
	assign advance    = valid_s1 && (!valid_s2 || cmd.ready);
	assign meas.ready = !valid_s1 || advance;
	assign accept     = meas.valid && meas.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gap_measured_s1   <= meas.gap_measured;
			gap_target_s1     <= meas.gap_target;
			leader_speed_a_s1 <= meas.leader_speed_a;
			leader_speed_b_s1 <= meas.leader_speed_b;
			own_speed_s1      <= meas.own_speed;
		end
	end

	gkp_datapath #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.cfg            (cfg),
		.gap_measured   (gap_measured_s1),
		.gap_target     (gap_target_s1),
		.leader_speed_a (leader_speed_a_s1),
		.leader_speed_b (leader_speed_b_s1),
		.own_speed      (own_speed_s1),
		.prev_err       (prev_err_q),
		.err_sum        (err_sum_q),
		.slow_latch     (slow_latch_q),
		.prev_err_nxt   (prev_err_nxt),
		.err_sum_nxt    (err_sum_nxt),
		.slow_latch_nxt (slow_latch_nxt),
		.speed_command  (speed_command_nxt),
		.in_deadband    (in_deadband_nxt)
	);

	// controller state commits when an item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q   <= '0;
			err_sum_q    <= '0;
			slow_latch_q <= 1'b0;
		end else if (advance) begin
			prev_err_q   <= prev_err_nxt;
			err_sum_q    <= err_sum_nxt;
			slow_latch_q <= slow_latch_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (cmd.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			speed_command_s2     <= speed_command_nxt;
			in_deadband_s2       <= in_deadband_nxt;
			slow_gains_active_s2 <= slow_latch_nxt;
		end
	end

	assign cmd.valid             = valid_s2;
	assign cmd.speed_command     = speed_command_s2;
	assign cmd.in_deadband       = in_deadband_s2;
	assign cmd.slow_gains_active = slow_gains_active_s2;

endmodule

`default_nettype wire

// ===== rtl/gkp_checker.sv =====
// Port-level checks for the gap-keeping controller, bound to the top level.
`default_nettype none

module gkp_checker import gkp_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic signed [DATA_WIDTH-1:0] speed_command,
	input wire logic                         in_deadband,
	input wire logic                         slow_gains_active
);

	logic       in_fire, out_fire;
	logic [2:0] pending_q;
	logic       slow_seen_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_fire) - 3'(out_fire);
		end
	end

	// slow gains reported on some delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_seen_q <= 1'b0;
		end else if (out_fire && slow_gains_active) begin
			slow_seen_q <= 1'b1;
		end
	end

	// no command without an item behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("command offered with no item outstanding");

	// at most the input and result registers hold items
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more than two items in flight");

	// the low-speed latch never releases
	a_slow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && slow_seen_q |-> slow_gains_active)
		else $error("slow gain latch released");

	// a stalled command holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(speed_command)
			&& $stable(in_deadband) && $stable(slow_gains_active))
		else $error("stalled command changed");

endmodule

bind gap_keeping_pid_speed_top gkp_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_gkp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (meas.valid),
	.in_ready          (meas.ready),
	.out_valid         (cmd.valid),
	.out_ready         (cmd.ready),
	.speed_command     (cmd.speed_command),
	.in_deadband       (cmd.in_deadband),
	.slow_gains_active (cmd.slow_gains_active)
);

`default_nettype wire
